>>> sv/dadsr_pkg.sv
// ----------------------------------------------------------------------------
// dadsr_pkg
// Shared types, constants and helpers of the DADSR envelope generator.
// ----------------------------------------------------------------------------
package dadsr_pkg;

  // build-time options of the voice
  localparam int unsigned REPEAT_SAMPLES = 0;   // 0 disables the repeat
  localparam int unsigned SHUTDOWN_SHIFT = 6;   // taper length is 2^shift ticks
  localparam bit          RESET_TO_ZERO  = 1'b1;
  localparam bit          LEGATO         = 1'b0;

  localparam int unsigned ENV_W    = 23;                       // Q1.22, 0..1.0
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned OFFS_W   = 24;
  localparam int unsigned BIAS_W   = 24;
  localparam int unsigned DLY_W    = 20;
  localparam int unsigned SEG_W    = 25;                       // segment result
  localparam int unsigned SHUT_W   = ENV_W + 1 - SHUTDOWN_SHIFT;
  localparam int unsigned PROD_W   = ENV_W + COEF_W;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(4194304);

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_DELAY   = 3'd1,
    PH_ATTACK  = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5,
    PH_SHUT    = 3'd6,
    PH_RSHUT   = 3'd7
  } dadsr_phase_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_STEAL = 2'd3
  } dadsr_cmd_e;

  typedef enum logic [2:0] {
    REG_ATTACK_COEFF   = 3'd0,
    REG_ATTACK_OFFSET  = 3'd1,
    REG_DECAY_COEFF    = 3'd2,
    REG_DECAY_OFFSET   = 3'd3,
    REG_RELEASE_COEFF  = 3'd4,
    REG_RELEASE_OFFSET = 3'd5,
    REG_SUSTAIN_LEVEL  = 3'd6,
    REG_DELAY_SAMPLES  = 3'd7
  } dadsr_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coeff;
    logic [OFFS_W-1:0] attack_offset;
    logic [COEF_W-1:0] decay_coeff;
    logic [OFFS_W-1:0] decay_offset;
    logic [COEF_W-1:0] release_coeff;
    logic [OFFS_W-1:0] release_offset;
    logic [ENV_W-1:0]  sustain_level;
    logic [DLY_W-1:0]  delay_samples;
  } dadsr_cfg_t;

  typedef struct packed {
    dadsr_phase_e      phase;
    logic [ENV_W-1:0]  env;
    logic [DLY_W-1:0]  delay_count;
    logic [DLY_W-1:0]  repeat_count;
    logic [SHUT_W-1:0] shut_step;
    logic              release_pending;
  } dadsr_state_t;

  // sustain level saturated to full scale
  function automatic logic [ENV_W-1:0] sus_sat(input logic [ENV_W-1:0] lvl);
    return (lvl > ENV_ONE) ? ENV_ONE : lvl;
  endfunction

  // saturate a signed segment result to 0..1.0
  function automatic logic [ENV_W-1:0] clamp_env(input logic signed [SEG_W-1:0] v);
    logic [ENV_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, ENV_ONE})) begin
      r = ENV_ONE;
    end else begin
      r = v[ENV_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/dadsr_regs.sv
// ----------------------------------------------------------------------------
// dadsr_regs
// APB-style register file holding the segment coefficients, offsets, sustain level and delay.
// ----------------------------------------------------------------------------
module dadsr_regs
  import dadsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dadsr_cfg_t        cfg_o
);

  dadsr_cfg_t cfg_q;
  dadsr_reg_e reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = dadsr_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff   <= '0;
      cfg_q.attack_offset  <= OFFS_W'(4194304);
      cfg_q.decay_coeff    <= '0;
      cfg_q.decay_offset   <= '0;
      cfg_q.release_coeff  <= '0;
      cfg_q.release_offset <= '1;
      cfg_q.sustain_level  <= ENV_ONE;
      cfg_q.delay_samples  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ATTACK_COEFF:   cfg_q.attack_coeff   <= pwdata[COEF_W-1:0];
        REG_ATTACK_OFFSET:  cfg_q.attack_offset  <= pwdata[OFFS_W-1:0];
        REG_DECAY_COEFF:    cfg_q.decay_coeff    <= pwdata[COEF_W-1:0];
        REG_DECAY_OFFSET:   cfg_q.decay_offset   <= pwdata[OFFS_W-1:0];
        REG_RELEASE_COEFF:  cfg_q.release_coeff  <= pwdata[COEF_W-1:0];
        REG_RELEASE_OFFSET: cfg_q.release_offset <= pwdata[OFFS_W-1:0];
        REG_SUSTAIN_LEVEL:  cfg_q.sustain_level  <= pwdata[ENV_W-1:0];
        REG_DELAY_SAMPLES:  cfg_q.delay_samples  <= pwdata[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ATTACK_COEFF:   prdata = DATA_W'(cfg_q.attack_coeff);
      REG_ATTACK_OFFSET:  prdata = DATA_W'(cfg_q.attack_offset);
      REG_DECAY_COEFF:    prdata = DATA_W'(cfg_q.decay_coeff);
      REG_DECAY_OFFSET:   prdata = DATA_W'(cfg_q.decay_offset);
      REG_RELEASE_COEFF:  prdata = DATA_W'(cfg_q.release_coeff);
      REG_RELEASE_OFFSET: prdata = DATA_W'(cfg_q.release_offset);
      REG_SUSTAIN_LEVEL:  prdata = DATA_W'(cfg_q.sustain_level);
      REG_DELAY_SAMPLES:  prdata = DATA_W'(cfg_q.delay_samples);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/dadsr_step.sv
// ----------------------------------------------------------------------------
// dadsr_step
// Next-state logic of the voice for one request: one multiply-add segment,
// the linear shutdown taper and the phase sequencing.
// ----------------------------------------------------------------------------
module dadsr_step
  import dadsr_pkg::*;
(
  input  dadsr_cfg_t   cfg_i,
  input  dadsr_state_t state_i,
  input  dadsr_cmd_e   cmd_i,
  input  logic         pedal_i,
  output dadsr_state_t state_o
);

  dadsr_phase_e             ph;
  logic [ENV_W-1:0]         env;
  logic [DLY_W-1:0]         dcnt;
  logic [DLY_W-1:0]         rcnt;
  logic [SHUT_W-1:0]        step;
  logic                     rp;
  logic [ENV_W-1:0]         sus;
  logic [COEF_W-1:0]        seg_coeff;
  logic [OFFS_W-1:0]        seg_offs;
  logic [PROD_W-1:0]        prod;
  logic signed [SEG_W-1:0]  seg_v;
  logic signed [SEG_W-1:0]  sub_v;
  logic [ENV_W:0]           ceil_sum;
  logic [SHUT_W-1:0]        shut_c;
  logic                     rep_hit;

  assign sus      = sus_sat(cfg_i.sustain_level);
  assign ceil_sum = {1'b0, state_i.env} + (ENV_W+1)'((1 << SHUTDOWN_SHIFT) - 1);
  assign shut_c   = SHUT_W'(ceil_sum >> SHUTDOWN_SHIFT);
  assign rep_hit  = (REPEAT_SAMPLES != 0) &&
                    (state_i.repeat_count >= DLY_W'(REPEAT_SAMPLES));
  assign sub_v    = $signed({2'b00, state_i.env}) -
                    $signed({{(SEG_W-SHUT_W){1'b0}}, state_i.shut_step});
  assign prod     = state_i.env * seg_coeff;
  assign seg_v    = $signed({seg_offs[OFFS_W-1], seg_offs}) +
                    $signed({2'b00, prod[PROD_W-1:COEF_W]});

  always_comb begin
    ph   = state_i.phase;
    env  = state_i.env;
    dcnt = state_i.delay_count;
    rcnt = state_i.repeat_count;
    step = state_i.shut_step;
    rp   = state_i.release_pending;

    // deferred note off once the pedal comes up
    if (rp && !pedal_i) begin
      rp = 1'b0;
      ph = (env != '0) ? PH_RELEASE : PH_OFF;
    end

    case (ph)
      PH_ATTACK: begin
        seg_coeff = cfg_i.attack_coeff;
        seg_offs  = cfg_i.attack_offset;
      end
      PH_DECAY: begin
        seg_coeff = cfg_i.decay_coeff;
        seg_offs  = cfg_i.decay_offset;
      end
      default: begin
        seg_coeff = cfg_i.release_coeff;
        seg_offs  = cfg_i.release_offset;
      end
    endcase

    case (cmd_i)
      CMD_TICK: begin
        case (ph)
          PH_OFF: begin
            if (RESET_TO_ZERO) begin
              env  = '0;
              dcnt = '0;
              rcnt = '0;
            end
          end
          PH_DELAY, PH_ATTACK, PH_DECAY, PH_SUSTAIN: begin
            if (rep_hit) begin
              step = shut_c;
              rp   = 1'b0;
              ph   = PH_RSHUT;
            end else begin
              if (REPEAT_SAMPLES != 0) begin
                rcnt = rcnt + DLY_W'(1);
              end
              case (ph)
                PH_DELAY: begin
                  if (cfg_i.delay_samples == '0 || dcnt >= cfg_i.delay_samples) begin
                    ph   = PH_ATTACK;
                    dcnt = '0;
                  end else begin
                    dcnt = dcnt + DLY_W'(1);
                  end
                end
                PH_ATTACK: begin
                  if (seg_v >= $signed({2'b00, ENV_ONE})) begin
                    env = ENV_ONE;
                    ph  = PH_DECAY;
                  end else begin
                    env = clamp_env(seg_v);
                  end
                end
                PH_DECAY: begin
                  if (seg_v <= $signed({2'b00, sus})) begin
                    env = sus;
                    ph  = PH_SUSTAIN;
                  end else begin
                    env = clamp_env(seg_v);
                  end
                end
                default: env = sus;
              endcase
            end
          end
          PH_RELEASE: begin
            if (!pedal_i) begin
              if (seg_v <= 0) begin
                env = '0;
                ph  = PH_OFF;
              end else begin
                env = clamp_env(seg_v);
              end
            end
          end
          PH_SHUT: begin
            if (RESET_TO_ZERO) begin
              if (sub_v <= 0) begin
                env = '0;
                ph  = PH_OFF;
              end else begin
                env = sub_v[ENV_W-1:0];
              end
            end else begin
              ph = PH_OFF;
            end
          end
          default: begin
            // repeat shutdown: taper, then retrigger at zero
            if (sub_v <= 0) begin
              env = '0;
              if (!LEGATO) begin
                dcnt = '0;
                rcnt = '0;
                ph   = PH_DELAY;
              end
            end else begin
              env = sub_v[ENV_W-1:0];
            end
          end
        endcase
      end
      CMD_ON: begin
        if (!LEGATO || ph == PH_OFF || ph == PH_RELEASE) begin
          if (RESET_TO_ZERO) begin
            env = '0;
          end
          dcnt = '0;
          rcnt = '0;
          ph   = PH_DELAY;
        end
      end
      CMD_OFF: begin
        if (pedal_i) begin
          rp = 1'b1;
        end else begin
          ph = (env != '0) ? PH_RELEASE : PH_OFF;
        end
      end
      default: begin
        if (!LEGATO) begin
          step = shut_c;
          rp   = 1'b0;
          ph   = PH_SHUT;
        end
      end
    endcase

    state_o.phase           = ph;
    state_o.env             = env;
    state_o.delay_count     = dcnt;
    state_o.repeat_count    = rcnt;
    state_o.shut_step       = step;
    state_o.release_pending = rp;
  end

endmodule

>>> sv/dadsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// dadsr_envelope_generator
// Single-voice delay-attack-decay-sustain-release envelope, Q1.22 fixed point.
// ----------------------------------------------------------------------------
// a request is accepted into the input register; once the result register is free,
//   one multiply-add pass loads its result into the result register
// throughput: one request per cycle unless out_stall_i holds the result; state
//   and result register load on the same edge, so the next request sees the new state
// reset: voice off, envelope zero, counters clear, registers at their defaults
module dadsr_envelope_generator
  import dadsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic                     sustain_pedal_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ENV_W-1:0]         env_out_o,
  output logic signed [BIAS_W-1:0] biased_out_o,
  output logic [2:0]               phase_code_o
);

  dadsr_cfg_t   cfg;
  dadsr_state_t state_q, state_d;

  logic              in_vld_q, in_vld_d;
  dadsr_cmd_e        cmd_q;
  logic              pedal_q;
  logic              out_vld_q, out_vld_d;
  logic [ENV_W-1:0]  env_out_q;
  logic [BIAS_W-1:0] biased_q;
  logic [2:0]        phase_q;
  logic              adv;
  logic              in_take;

  dadsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dadsr_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .cmd_i   (cmd_q),
    .pedal_i (pedal_q),
    .state_o (state_d)
  );

  // a request moves on when the result register is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !adv);
  assign out_vld_d  = adv || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q                <= 1'b0;
      out_vld_q               <= 1'b0;
      state_q.phase           <= PH_OFF;
      state_q.env             <= '0;
      state_q.delay_count     <= '0;
      state_q.repeat_count    <= '0;
      state_q.shut_step       <= '0;
      state_q.release_pending <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= dadsr_cmd_e'(cmd_i);
      pedal_q <= sustain_pedal_i;
    end
    if (adv) begin
      env_out_q <= state_d.env;
      biased_q  <= BIAS_W'({1'b0, state_d.env} - {1'b0, sus_sat(cfg.sustain_level)});
      phase_q   <= state_d.phase;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign env_out_o    = env_out_q;
  assign biased_out_o = $signed(biased_q);
  assign phase_code_o = phase_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DADSR envelope generator: queued commands are
// driven with random gaps, every result is checked against a local voice model.
// ----------------------------------------------------------------------------
module tb;
  import dadsr_pkg::*;

  localparam int ONE_Q22     = 4194304;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    dadsr_cmd_e cmd;
    logic       pedal;
  } env_req_t;

  typedef struct packed {
    logic [ENV_W-1:0]  env;
    logic [BIAS_W-1:0] biased;
    dadsr_phase_e      phase;
  } env_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i = CMD_TICK;
  logic              sustain_pedal_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ENV_W-1:0]  env_out_o;
  logic signed [BIAS_W-1:0] biased_out_o;
  logic [2:0]        phase_code_o;

  env_req_t    req_q[$];
  env_result_t env_q[$];
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_err = 0;
  int          cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  bit          hold_armed = 1'b0;
  int          hold_left = 0;
  bit          taken = 1'b0;

  // voice model: register copy
  logic [COEF_W-1:0]        m_atk_coeff, m_dec_coeff, m_rel_coeff;
  logic signed [OFFS_W-1:0] m_atk_offs, m_dec_offs, m_rel_offs;
  logic [ENV_W-1:0]         m_sustain;
  logic [DLY_W-1:0]         m_delay;
  // voice model: state
  dadsr_phase_e             m_phase;
  int                       m_env;
  logic [DLY_W-1:0]         m_dly_cnt, m_rep_cnt;
  int                       m_shut_step;
  bit                       m_rel_pend;

  dadsr_envelope_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .sustain_pedal_i (sustain_pedal_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .env_out_o       (env_out_o),
    .biased_out_o    (biased_out_o),
    .phase_code_o    (phase_code_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic int sustain_sat();
    return (m_sustain > ENV_ONE) ? ONE_Q22 : int'(m_sustain);
  endfunction

  function automatic int env_sat(longint v);
    if (v < 0) begin
      return 0;
    end
    if (v > ONE_Q22) begin
      return ONE_Q22;
    end
    return int'(v);
  endfunction

  // one-pole segment: offset + floor(env * coeff / 2^24)
  function automatic longint segment_next(logic signed [OFFS_W-1:0] offs,
                                          logic [COEF_W-1:0] coeff);
    longint prod;
    prod = longint'(m_env) * longint'(coeff);
    return longint'(offs) + (prod >>> 24);
  endfunction

  function automatic void voice_start();
    if (LEGATO && m_phase != PH_OFF && m_phase != PH_RELEASE) begin
      return;
    end
    if (RESET_TO_ZERO) begin
      m_env = 0;
    end
    m_dly_cnt = '0;
    m_rep_cnt = '0;
    m_phase = PH_DELAY;
  endfunction

  function automatic void shutdown_begin();
    longint e;
    e = (m_env < 0) ? 0 : m_env;
    m_shut_step = int'((e + (longint'(1) << SHUTDOWN_SHIFT) - 1) >>> SHUTDOWN_SHIFT);
    m_rel_pend = 1'b0;
  endfunction

  function automatic void voice_release();
    m_phase = (m_env > 0) ? PH_RELEASE : PH_OFF;
  endfunction

  function automatic bit repeat_due();
    if (REPEAT_SAMPLES == 0) begin
      return 1'b0;
    end
    if (m_rep_cnt >= REPEAT_SAMPLES) begin
      shutdown_begin();
      m_phase = PH_RSHUT;
      return 1'b1;
    end
    m_rep_cnt = m_rep_cnt + DLY_W'(1);
    return 1'b0;
  endfunction

  function automatic void sample_advance(logic pedal);
    longint v;
    case (m_phase)
      PH_OFF: begin
        if (RESET_TO_ZERO) begin
          m_env = 0;
          m_dly_cnt = '0;
          m_rep_cnt = '0;
        end
      end
      PH_DELAY: begin
        if (!repeat_due()) begin
          if (m_delay == 0 || m_dly_cnt >= m_delay) begin
            m_phase = PH_ATTACK;
            m_dly_cnt = '0;
          end else begin
            m_dly_cnt = m_dly_cnt + DLY_W'(1);
          end
        end
      end
      PH_ATTACK: begin
        if (!repeat_due()) begin
          v = segment_next(m_atk_offs, m_atk_coeff);
          if (v >= ONE_Q22) begin
            m_env = ONE_Q22;
            m_phase = PH_DECAY;
          end else begin
            m_env = env_sat(v);
          end
        end
      end
      PH_DECAY: begin
        if (!repeat_due()) begin
          v = segment_next(m_dec_offs, m_dec_coeff);
          if (v <= sustain_sat()) begin
            m_env = sustain_sat();
            m_phase = PH_SUSTAIN;
          end else begin
            m_env = env_sat(v);
          end
        end
      end
      PH_SUSTAIN: begin
        if (!repeat_due()) begin
          m_env = sustain_sat();
        end
      end
      PH_RELEASE: begin
        // a held pedal freezes the release
        if (!pedal) begin
          v = segment_next(m_rel_offs, m_rel_coeff);
          if (v <= 0) begin
            m_env = 0;
            m_phase = PH_OFF;
          end else begin
            m_env = env_sat(v);
          end
        end
      end
      PH_SHUT: begin
        if (RESET_TO_ZERO) begin
          v = longint'(m_env) - m_shut_step;
          if (v <= 0) begin
            m_env = 0;
            m_phase = PH_OFF;
          end else begin
            m_env = env_sat(v);
          end
        end else begin
          m_phase = PH_OFF;
        end
      end
      default: begin
        v = longint'(m_env) - m_shut_step;
        if (v <= 0) begin
          m_env = 0;
          voice_start();
        end else begin
          m_env = env_sat(v);
        end
      end
    endcase
  endfunction

  function automatic env_result_t voice_step(dadsr_cmd_e cmd, logic pedal);
    env_result_t r;
    // pedal lifted with a note off pending
    if (m_rel_pend && !pedal) begin
      m_rel_pend = 1'b0;
      voice_release();
    end
    case (cmd)
      CMD_TICK: sample_advance(pedal);
      CMD_ON:   voice_start();
      CMD_OFF: begin
        if (pedal) begin
          m_rel_pend = 1'b1;
        end else begin
          voice_release();
        end
      end
      default: begin
        if (!LEGATO) begin
          shutdown_begin();
          m_phase = PH_SHUT;
        end
      end
    endcase
    m_env = env_sat(m_env);
    r.env = m_env[ENV_W-1:0];
    r.biased = BIAS_W'(m_env - sustain_sat());
    r.phase = m_phase;
    return r;
  endfunction

  function automatic void voice_reset();
    m_atk_coeff = '0;
    m_atk_offs = OFFS_W'(ONE_Q22);
    m_dec_coeff = '0;
    m_dec_offs = '0;
    m_rel_coeff = '0;
    m_rel_offs = -1;
    m_sustain = ENV_ONE;
    m_delay = '0;
    m_phase = PH_OFF;
    m_env = 0;
    m_dly_cnt = '0;
    m_rep_cnt = '0;
    m_shut_step = 0;
    m_rel_pend = 1'b0;
  endfunction

  // ---------------------------------------------------------------- request side

  always @(posedge clk_i) begin : req_accept
    env_req_t r;
    taken = rst_ni && in_valid_i && !in_stall_o;
    if (taken) begin
      r.cmd = dadsr_cmd_e'(cmd_i);
      r.pedal = sustain_pedal_i;
      env_q.push_back(voice_step(r.cmd, r.pedal));
      n_taken++;
    end
  end

  always @(negedge clk_i) begin : req_drive
    env_req_t r;
    if (!in_valid_i || taken) begin
      if (rst_ni && req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        r = req_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= r.cmd;
        sustain_pedal_i <= r.pedal;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result side

  always @(negedge clk_i) begin : result_stall
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    env_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (env_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected result: env %0d biased %0d phase %0d",
                   env_out_o, biased_out_o, phase_code_o);
        end
      end else begin
        want = env_q.pop_front();
        if (env_out_o !== want.env || biased_out_o !== want.biased ||
            phase_code_o !== want.phase) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch: env %0d/%0d biased %0d/%0d phase %0d/%0d (exp/got)",
                     want.env, env_out_o, $signed(want.biased), biased_out_o,
                     want.phase, phase_code_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dadsr_envelope_generator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic reg_write(dadsr_reg_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_ATTACK_COEFF:   m_atk_coeff = val[COEF_W-1:0];
      REG_ATTACK_OFFSET:  m_atk_offs = val[OFFS_W-1:0];
      REG_DECAY_COEFF:    m_dec_coeff = val[COEF_W-1:0];
      REG_DECAY_OFFSET:   m_dec_offs = val[OFFS_W-1:0];
      REG_RELEASE_COEFF:  m_rel_coeff = val[COEF_W-1:0];
      REG_RELEASE_OFFSET: m_rel_offs = val[OFFS_W-1:0];
      REG_SUSTAIN_LEVEL:  m_sustain = val[ENV_W-1:0];
      default:            m_delay = val[DLY_W-1:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic config_all(int atk_c, int atk_o, int dec_c, int dec_o,
                            int rel_c, int rel_o, int sus, int dly);
    reg_write(REG_ATTACK_COEFF, DATA_W'(atk_c));
    reg_write(REG_ATTACK_OFFSET, DATA_W'(atk_o) & 32'hFF_FFFF);
    reg_write(REG_DECAY_COEFF, DATA_W'(dec_c));
    reg_write(REG_DECAY_OFFSET, DATA_W'(dec_o) & 32'hFF_FFFF);
    reg_write(REG_RELEASE_COEFF, DATA_W'(rel_c));
    reg_write(REG_RELEASE_OFFSET, DATA_W'(rel_o) & 32'hFF_FFFF);
    reg_write(REG_SUSTAIN_LEVEL, DATA_W'(sus));
    reg_write(REG_DELAY_SAMPLES, DATA_W'(dly));
  endtask

  // segments that converge past their end point within tens of ticks
  task automatic config_musical(int dly);
    int sus;
    if ($urandom_range(3) == 0) begin
      sus = int'($urandom_range(ONE_Q22 + 1, 8388607));
    end else begin
      sus = int'($urandom_range(0, ONE_Q22));
    end
    config_all(int'($urandom_range(8388608, 16777215)),
               int'($urandom_range(ONE_Q22 / 64, ONE_Q22 / 2)),
               int'($urandom_range(12000000, 16777215)),
               -int'($urandom_range(0, ONE_Q22 / 32)),
               int'($urandom_range(12000000, 16777215)),
               -int'($urandom_range(1, ONE_Q22 / 32)),
               sus, dly);
  endtask

  task automatic push_req(dadsr_cmd_e c, logic p);
    env_req_t r;
    r.cmd = c;
    r.pedal = p;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_ticks(int n, inout logic p);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        p = !p;
      end
      push_req(CMD_TICK, p);
    end
  endtask

  // mostly whole notes with random timing, some noise in between
  task automatic queue_notes(int n);
    int stop;
    logic p;
    stop = n_queued + n;
    p = 1'b0;
    while (n_queued < stop) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 8)) begin
          push_req(dadsr_cmd_e'($urandom_range(3)), 1'($urandom_range(1)));
        end
      end else begin
        p = ($urandom_range(9) == 0);
        push_req(CMD_ON, p);
        push_ticks($urandom_range(0, 60), p);
        if ($urandom_range(4) == 0) begin
          push_req(CMD_STEAL, p);
          push_ticks($urandom_range(0, 70), p);
        end else begin
          if ($urandom_range(3) == 0) begin
            p = 1'b1;
          end
          push_req(CMD_OFF, p);
          push_ticks($urandom_range(0, 50), p);
          if ($urandom_range(5) == 0) begin
            push_req(CMD_ON, p);
            push_ticks($urandom_range(0, 10), p);
          end
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (!(n_taken == n_queued && env_q.size() == 0)) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int src_pct, int sink_pct, bit press);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    queue_notes(n);
    if (press) begin
      hold_armed = 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    voice_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset register values: instant attack, instant decay, one-tick release
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_OFF, 1'b0);
    push_req(CMD_STEAL, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_ON, 1'b1);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_OFF, 1'b1);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_ON, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_STEAL, 1'b0);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_ON, 1'b0);
    push_req(CMD_OFF, 1'b0);
    push_req(CMD_ON, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_TICK, 1'b0);
    push_req(CMD_OFF, 1'b0);
    push_req(CMD_TICK, 1'b1);
    push_req(CMD_ON, 1'b1);
    wait_drained();

    // maximum values, sustain above full scale
    config_all(16777215, 8388607, 16777215, -8388608, 16777215, -8388608,
               8388607, 0);
    run_phase(200, 0, 0, 1'b0);

    config_musical($urandom_range(0, 6));
    run_phase(240, 70, 0, 1'b0);

    // minimum values: attack stuck at zero, release stuck at full scale
    config_all(0, -8388608, 0, 8388607, 0, 8388607, 0, 0);
    run_phase(160, 0, 70, 1'b0);

    config_musical($urandom_range(0, 6));
    run_phase(240, 35, 35, 1'b0);

    // long receiver hold-off fills the pipe
    config_musical($urandom_range(0, 3));
    run_phase(240, 0, 0, 1'b1);

    // longest delay: the voice never leaves delay after a note on
    config_musical(1048575);
    run_phase(50, 35, 35, 1'b0);

    config_musical($urandom_range(0, 6));
    run_phase(120, 0, 0, 1'b0);

    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("dadsr_envelope_generator regression: pass");
    end else begin
      $display("dadsr_envelope_generator regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dadsr_pkg.sv
sv/dadsr_regs.sv
sv/dadsr_step.sv
sv/dadsr_envelope_generator.sv
tb/tb.sv
